// ===== hdl/pim_pkg.sv =====
// Shared types, constants and the microcode table of the pointer inertia block.
package pim_pkg;

	// Datapath widths fixed by the item and register fields
	localparam int SPEED_W   = 8;
	localparam int DIVIDEND_W = 16;
	localparam int QUO_W     = 15;
	localparam int DIVISOR_W = 7;
	localparam int DIV_CNT_W = 3;
	localparam int ACC_W     = 30;

	// Step counter of the microcode sequencer
	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_IDLE    = 4'd0;
	localparam step_t STEP_INIT    = 4'd1;
	localparam step_t STEP_FRIC    = 4'd2;
	localparam step_t STEP_ACCEL   = 4'd3;
	localparam step_t STEP_DIVGO   = 4'd4;
	localparam step_t STEP_DIVWAIT = 4'd5;
	localparam step_t STEP_SQ      = 4'd6;
	localparam step_t STEP_SCALE   = 4'd7;
	localparam step_t STEP_SAT     = 4'd8;
	localparam step_t STEP_JTEND   = 4'd9;
	localparam step_t STEP_TFIRST  = 4'd10;
	localparam step_t STEP_TEND    = 4'd11;
	localparam step_t STEP_PCHK    = 4'd12;
	localparam step_t STEP_PFIRST  = 4'd13;
	localparam step_t STEP_EMIT    = 4'd14;

	// Datapath operations
	typedef enum logic [3:0] {
		UOP_NOP,
		UOP_LOAD,
		UOP_INIT,
		UOP_FRIC,
		UOP_ACCEL,
		UOP_DIVGO,
		UOP_SQ,
		UOP_SCALE,
		UOP_SAT,
		UOP_FIRST,
		UOP_TEND,
		UOP_EMIT
	} uop_t;

	// Jump conditions
	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_PRESS,
		COND_FRAME_Z,
		COND_FRAME_NZ,
		COND_AX_X
	} cond_t;

	// Hold reasons: the step repeats until the event has come
	typedef enum logic [1:0] {
		WAIT_NONE,
		WAIT_IN,
		WAIT_DIV,
		WAIT_OUT
	} stall_t;

	// Configuration register indexes
	typedef enum logic [7:0] {
		REG_ACCEL_LIMIT = 8'd0,
		REG_TOP_SPEED   = 8'd1,
		REG_FRICTION    = 8'd2,
		REG_FIRST_STEP  = 8'd3
	} reg_idx_t;

	typedef struct packed {
		uop_t   uop;
		stall_t stall;
		cond_t  cond;
		logic   tog;
		step_t  target;
	} cw_t;

	typedef struct packed {
		step_t step;
		uop_t  uop;
		logic  tog;
		logic  en;
		logic  idle;
	} ctrl_t;

	typedef struct packed {
		logic press;
		logic frame_zero;
		logic axis;
		logic div_busy;
	} dp_stat_t;

	typedef struct packed {
		dp_stat_t dp;
		logic     in_valid;
		logic     out_busy;
	} stat_t;

	typedef struct packed {
		logic signed [7:0] move_x;
		logic signed [7:0] move_y;
		logic              report_valid;
		logic              motion_stopped;
		logic              use_start_delay;
	} result_t;

	// Microcode program, one control word per step
	function automatic cw_t ucode(input step_t s);
		cw_t cw;
		cw = '{uop: UOP_NOP, stall: WAIT_NONE, cond: COND_ALWAYS, tog: 1'b0, target: STEP_IDLE};
		case (s)
			STEP_IDLE: begin
				cw.uop = UOP_LOAD; cw.stall = WAIT_IN; cw.cond = COND_NEVER;
			end
			STEP_INIT: begin
				cw.uop = UOP_INIT; cw.cond = COND_PRESS; cw.target = STEP_PCHK;
			end
			STEP_FRIC: begin
				cw.uop = UOP_FRIC; cw.cond = COND_NEVER;
			end
			STEP_ACCEL: begin
				cw.uop = UOP_ACCEL; cw.cond = COND_FRAME_Z; cw.target = STEP_TFIRST;
			end
			STEP_DIVGO: begin
				cw.uop = UOP_DIVGO; cw.cond = COND_NEVER;
			end
			STEP_DIVWAIT: begin
				cw.stall = WAIT_DIV; cw.cond = COND_NEVER;
			end
			STEP_SQ: begin
				cw.uop = UOP_SQ; cw.cond = COND_NEVER;
			end
			STEP_SCALE: begin
				cw.uop = UOP_SCALE; cw.cond = COND_NEVER;
			end
			STEP_SAT: begin
				cw.uop = UOP_SAT; cw.tog = 1'b1; cw.cond = COND_AX_X; cw.target = STEP_FRIC;
			end
			STEP_JTEND: begin
				cw.target = STEP_TEND;
			end
			STEP_TFIRST: begin
				cw.uop = UOP_FIRST; cw.tog = 1'b1; cw.cond = COND_AX_X; cw.target = STEP_FRIC;
			end
			STEP_TEND: begin
				cw.uop = UOP_TEND; cw.target = STEP_EMIT;
			end
			STEP_PCHK: begin
				cw.cond = COND_FRAME_NZ; cw.target = STEP_EMIT;
			end
			STEP_PFIRST: begin
				cw.uop = UOP_FIRST; cw.tog = 1'b1; cw.cond = COND_AX_X; cw.target = STEP_PFIRST;
			end
			STEP_EMIT: begin
				cw.uop = UOP_EMIT; cw.stall = WAIT_OUT; cw.target = STEP_IDLE;
			end
			default: begin
				cw.target = STEP_IDLE;
			end
		endcase
		return cw;
	endfunction

endpackage

// ===== hdl/pim_channels.sv =====
// Valid/ready channel interfaces for items, results and configuration writes.
interface pim_item_if;
	logic              valid;
	logic              ready;
	logic              op;
	logic signed [1:0] press_x_dir;
	logic signed [1:0] press_y_dir;

	modport source (output valid, output op, output press_x_dir, output press_y_dir,
		input ready);
	modport sink (input valid, input op, input press_x_dir, input press_y_dir,
		output ready);
endinterface

interface pim_result_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] move_x;
	logic signed [7:0] move_y;
	logic              report_valid;
	logic              motion_stopped;
	logic              use_start_delay;

	modport source (output valid, output move_x, output move_y, output report_valid,
		output motion_stopped, output use_start_delay, input ready);
	modport sink (input valid, input move_x, input move_y, input report_valid,
		input motion_stopped, input use_start_delay, output ready);
endinterface

interface pim_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/pim_divider.sv =====
// Restoring divider, two quotient bits per cycle.
module pim_divider (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [pim_pkg::DIVIDEND_W-1:0]     dividend,
	input  logic [pim_pkg::DIVISOR_W-1:0]      divisor,
	output logic                               busy,
	output logic [pim_pkg::QUO_W-1:0]          quotient
);
	import pim_pkg::*;

	logic                  busy_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] sh_q;
	logic [DIVISOR_W-1:0]  div_q;
	logic [DIVISOR_W-1:0]  rem_n;
	logic [DIVIDEND_W-1:0] sh_n;

	// Two dependent shift/subtract steps; dividend bits leave at the top,
	// quotient bits enter at the bottom
	always_comb begin
		logic [DIVISOR_W:0] t;
		rem_n = rem_q;
		sh_n  = sh_q;
		for (int i = 0; i < 2; i++) begin
			t    = {rem_n, sh_n[DIVIDEND_W-1]};
			sh_n = {sh_n[DIVIDEND_W-2:0], 1'b0};
			if (t >= {1'b0, div_q}) begin
				t       = t - {1'b0, div_q};
				sh_n[0] = 1'b1;
			end
			rem_n = t[DIVISOR_W-1:0];
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '1;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			sh_q  <= sh_n;
			rem_q <= rem_n;
		end
	end

	assign busy     = busy_q;
	assign quotient = sh_q[QUO_W-1:0];

endmodule

// ===== hdl/pim_datapath.sv =====
// Datapath: configuration, axis state, friction, curve and saturation units.
module pim_datapath #(
	parameter int MOVE_LIMIT = 127
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pim_pkg::ctrl_t    ctrl,
	input  logic              item_op,
	input  logic signed [1:0] item_x_dir,
	input  logic signed [1:0] item_y_dir,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	output pim_pkg::dp_stat_t stat,
	output pim_pkg::result_t  res
);
	import pim_pkg::*;

	localparam logic [7:0] LIM = 8'(MOVE_LIMIT);

	// Configuration
	logic [6:0] accel_q;
	logic [7:0] top_q;
	logic [7:0] fric_q;
	logic [6:0] first_q;

	// Motion state
	logic signed [SPEED_W-1:0] spd_q [2];
	logic signed [1:0]         hd_q  [2];
	logic [7:0]                frame_q;
	logic                      ax_q;

	// Item and work registers
	logic                      op_q;
	logic signed [1:0]         dx_q;
	logic signed [1:0]         dy_q;
	logic [ACC_W-1:0]          acc_q;
	logic signed [7:0]         mv_q [2];
	logic                      stop_q;
	logic                      delay_q;

	logic signed [SPEED_W-1:0] v;
	logic signed [1:0]         h;
	logic signed [8:0]         v9;
	logic [6:0]                lim;
	logic signed [8:0]         lim_s;
	logic [8:0]                keep;
	logic                      fric_neg;
	logic                      fric_pos;
	logic signed [8:0]         fric_a;
	logic signed [18:0]        fric_p;
	logic signed [18:0]        fric_r;
	logic signed [SPEED_W-1:0] v_fric;
	logic signed [SPEED_W-1:0] v_accel;
	logic [7:0]                abs_v;
	logic [DIVIDEND_W-1:0]     dividend;
	logic                      div_busy;
	logic [QUO_W-1:0]          quo;
	logic [ACC_W-1:0]          sq;
	logic [ACC_W-1:0]          scale;
	logic [ACC_W:0]            rnd;
	logic [22:0]               mag;
	logic [7:0]                sat_m;
	logic signed [7:0]         mv_curve;
	logic signed [9:0]         fp;
	logic signed [9:0]         lim10;
	logic signed [7:0]         mv_first;
	logic                      div_start;

	assign v     = spd_q[ax_q];
	assign h     = hd_q[ax_q];
	assign v9    = 9'(v);
	assign lim   = (accel_q == '0) ? 7'd1 : accel_q;
	assign lim_s = $signed({2'b00, lim});
	assign keep  = 9'd256 - {1'b0, fric_q};

	// Friction: scale by keep/256, truncated toward zero
	assign fric_neg = !h[1] && v[SPEED_W-1];
	assign fric_pos = (h[1] || h == 2'sd0) && !v[SPEED_W-1] && (v != '0);
	assign fric_a   = fric_neg ? (v9 + 9'sd1) : v9;
	assign fric_p   = 19'(fric_a) * $signed({10'b0, keep});
	assign fric_r   = fric_neg ? ((fric_p + 19'sd255) >>> 8) : (fric_p >>> 8);

	always_comb begin
		v_fric = v;
		if (fric_neg || fric_pos) begin
			v_fric = fric_r[SPEED_W-1:0];
		end
	end

	// One unit toward the heading, bounded by the limit
	always_comb begin
		v_accel = v;
		if (!h[1] && h != 2'sd0 && v9 < lim_s) begin
			v_accel = v + 8'sd1;
		end else if (h[1] && v9 > -lim_s) begin
			v_accel = v - 8'sd1;
		end
	end

	// Curve: |v|*256/limit through the divider, squared, scaled by top speed
	assign abs_v     = v[SPEED_W-1] ? (8'd0 - v) : v;
	assign dividend  = {1'b0, abs_v[6:0], 8'b0};
	assign div_start = ctrl.en && ctrl.uop == UOP_DIVGO;
	assign sq        = ACC_W'(quo) * ACC_W'(quo);
	assign scale     = ACC_W'(top_q) * acc_q;

	pim_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (lim),
		.busy     (div_busy),
		.quotient (quo)
	);

	// Floor for positive velocity, ceiling for negative, plus the sign unit
	assign rnd      = v[SPEED_W-1] ? ({1'b0, acc_q} + (ACC_W+1)'(255)) : {1'b0, acc_q};
	assign mag      = rnd[ACC_W:8] + {22'b0, (v != '0)};
	assign sat_m    = (mag > {15'b0, LIM}) ? LIM : mag[7:0];
	assign mv_curve = v[SPEED_W-1] ? $signed(8'd0 - sat_m) : $signed(sat_m);

	// First-frame move: heading times first step, saturated
	assign fp    = 10'(h) * $signed({3'b000, first_q});
	assign lim10 = $signed({2'b00, LIM});

	always_comb begin
		mv_first = fp[7:0];
		if (fp > lim10) begin
			mv_first = $signed(LIM);
		end else if (fp < -lim10) begin
			mv_first = $signed(8'd0 - LIM);
		end
	end

	// Configuration and motion state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q  <= 7'd32;
			top_q    <= 8'd16;
			fric_q   <= 8'd24;
			first_q  <= 7'd1;
			spd_q[0] <= '0;
			spd_q[1] <= '0;
			hd_q[0]  <= '0;
			hd_q[1]  <= '0;
			frame_q  <= '0;
			ax_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ACCEL_LIMIT: accel_q <= cfg_data[6:0];
					REG_TOP_SPEED:   top_q   <= cfg_data;
					REG_FRICTION:    fric_q  <= cfg_data;
					REG_FIRST_STEP:  first_q <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (ctrl.en) begin
				if (ctrl.tog) begin
					ax_q <= !ax_q;
				end
				case (ctrl.uop)
					UOP_INIT: begin
						ax_q <= 1'b0;
						if (op_q && dx_q != 2'sd0) begin
							hd_q[0] <= dx_q;
						end
						if (op_q && dy_q != 2'sd0) begin
							hd_q[1] <= dy_q;
						end
					end
					UOP_FRIC:  spd_q[ax_q] <= v_fric;
					UOP_ACCEL: spd_q[ax_q] <= v_accel;
					UOP_TEND: begin
						if (hd_q[0] == 2'sd0 && hd_q[1] == 2'sd0 &&
								spd_q[0] == '0 && spd_q[1] == '0) begin
							frame_q <= '0;
						end else begin
							frame_q <= frame_q + 8'd1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Item latch and work registers
	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			case (ctrl.uop)
				UOP_LOAD: begin
					op_q <= item_op;
					dx_q <= item_x_dir;
					dy_q <= item_y_dir;
				end
				UOP_INIT: begin
					mv_q[0] <= '0;
					mv_q[1] <= '0;
					stop_q  <= 1'b0;
					delay_q <= op_q && (frame_q == '0);
				end
				UOP_SQ:    acc_q <= sq >> 8;
				UOP_SCALE: acc_q <= scale;
				UOP_SAT:   mv_q[ax_q] <= mv_curve;
				UOP_FIRST: mv_q[ax_q] <= mv_first;
				UOP_TEND: begin
					stop_q <= hd_q[0] == 2'sd0 && hd_q[1] == 2'sd0 &&
						spd_q[0] == '0 && spd_q[1] == '0;
				end
				default: ;
			endcase
		end
	end

	assign stat.press      = op_q;
	assign stat.frame_zero = (frame_q == '0);
	assign stat.axis       = ax_q;
	assign stat.div_busy   = div_busy;

	assign res.move_x          = mv_q[0];
	assign res.move_y          = mv_q[1];
	assign res.report_valid    = (mv_q[0] != '0) || (mv_q[1] != '0);
	assign res.motion_stopped  = stop_q;
	assign res.use_start_delay = delay_q;

endmodule

// ===== hdl/pim_sequencer.sv =====
// Microcode sequencer: step counter, control word fetch, hold and jump logic.
module pim_sequencer (
	input  logic           clk,
	input  logic           arst_n,
	input  pim_pkg::stat_t stat,
	output pim_pkg::ctrl_t ctrl
);
	import pim_pkg::*;

	step_t step_q;
	step_t step_n;
	cw_t   cw;
	logic  hold;
	logic  take;

	assign cw = ucode(step_q);

	// Hold, jump condition and next step
	always_comb begin
		case (cw.stall)
			WAIT_IN:  hold = !stat.in_valid;
			WAIT_DIV: hold = stat.dp.div_busy;
			WAIT_OUT: hold = stat.out_busy;
			default:  hold = 1'b0;
		endcase
		case (cw.cond)
			COND_ALWAYS:   take = 1'b1;
			COND_PRESS:    take = stat.dp.press;
			COND_FRAME_Z:  take = stat.dp.frame_zero;
			COND_FRAME_NZ: take = !stat.dp.frame_zero;
			COND_AX_X:     take = !stat.dp.axis;
			default:       take = 1'b0;
		endcase
		if (hold) begin
			step_n = step_q;
		end else if (take) begin
			step_n = cw.target;
		end else begin
			step_n = step_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_n;
		end
	end

	assign ctrl.step = step_q;
	assign ctrl.uop  = cw.uop;
	assign ctrl.tog  = cw.tog;
	assign ctrl.en   = !hold;
	assign ctrl.idle = (cw.stall == WAIT_IN);

endmodule

// ===== hdl/pointer_inertia_motion.sv =====
// Top level of the two-axis pointer motion block with inertia.
//
// Items enter on the item channel: op 1 is a key press that loads the axis
// headings, op 0 is a tick that applies friction and acceleration and moves
// the pointer. Every item yields exactly one transfer on the result channel.
// The cfg channel writes accel_limit, top_speed, friction_amount and
// first_step by index; it is always ready, and the user must write it only
// while idle: the block does not enforce this. One item is worked on at a
// time by a microcoded sequencer over a shared datapath. A press on frame
// zero sets the first-frame moves; a tick applies friction and acceleration,
// then sets them on frame zero or else runs the curve once per axis through
// the serial divider, two quotient bits a cycle, and two registered multiplies.
// The sequencer returns to its idle step as the result is loaded, so the next
// item can transfer in the cycle after. The result sits in an output register;
// if the receiver stalls, the next item is still accepted and runs until its
// own result is due, then waits. Reset restores the default register values,
// clears velocities, headings and frame count, and leaves the result channel
// empty.
module pointer_inertia_motion #(
	parameter int MOVE_LIMIT = 127
) (
	input  logic         clk,
	input  logic         arst_n,
	pim_item_if.sink     item,
	pim_result_if.source result,
	pim_cfg_if.sink      cfg
);
	import pim_pkg::*;

	ctrl_t    ctrl;
	dp_stat_t dp_stat;
	stat_t    stat;
	result_t  res;
	result_t  out_q;
	logic     out_valid_q;
	logic     emit;

	assign stat.dp       = dp_stat;
	assign stat.in_valid = item.valid;
	assign stat.out_busy = out_valid_q && !result.ready;

	assign item.ready = ctrl.idle;
	assign cfg.ready  = 1'b1;

	pim_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	pim_datapath #(
		.MOVE_LIMIT (MOVE_LIMIT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.item_op    (item.op),
		.item_x_dir (item.press_x_dir),
		.item_y_dir (item.press_y_dir),
		.cfg_we     (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.stat       (dp_stat),
		.res        (res)
	);

	// Output register
	assign emit = ctrl.en && ctrl.uop == UOP_EMIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.move_x          = out_q.move_x;
	assign result.move_y          = out_q.move_y;
	assign result.report_valid    = out_q.report_valid;
	assign result.motion_stopped  = out_q.motion_stopped;
	assign result.use_start_delay = out_q.use_start_delay;

`ifndef SYNTHESIS
	// A new result never lands on one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !(out_valid_q && !result.ready))
		else $error("result register overwritten before transfer");

	// The divider only runs while the program waits on it
	a_div_step: assert property (@(posedge clk) disable iff (!arst_n)
		dp_stat.div_busy |-> ctrl.step == STEP_DIVWAIT)
		else $error("divider busy outside its wait step");

	// A tick that stops motion carries no movement
	a_stop_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.motion_stopped) |->
			(out_q.move_x == 8'sd0 && out_q.move_y == 8'sd0 && !out_q.report_valid))
		else $error("stopped result carries movement");
`endif

endmodule

// ===== sim/pim_tb_pkg.sv =====
// Item opcodes shared by the pointer motion stimulus and its checker.
package pim_tb_pkg;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_PRESS = 1'b1
	} item_op_t;

endpackage

// ===== sim/pim_motion_checker.sv =====
// Channel monitor that predicts pointer moves and compares them with the block output.
module pim_motion_checker (
	input  logic  clk,
	input  logic  arst_n,
	pim_item_if   item,
	pim_result_if result,
	pim_cfg_if    cfg,
	output int    mismatches,
	output int    outstanding
);
	import pim_pkg::*;
	import pim_tb_pkg::*;

	localparam int MOVE_LIMIT = 127;

	// Register copies
	logic [6:0] accel_lim;
	logic [7:0] top_spd;
	logic [7:0] friction;
	logic [6:0] first_stp;

	// Motion state copies
	logic signed [7:0] speed_x, speed_y;
	logic [7:0]        frames;
	logic signed [1:0] heading_x, heading_y;

	result_t moves_due[$];
	int      fail_count;

	assign mismatches = fail_count;

	function automatic int limit_or_one();
		return (accel_lim == 7'd0) ? 1 : int'(accel_lim);
	endfunction

	// Friction against or without heading, then one step toward the heading
	function automatic int friction_then_accel(input int dir, input int v);
		int keep;
		int lim;
		keep = 256 - int'(friction);
		lim = limit_or_one();
		if (dir > -1 && v < 0)
			v = ((v + 1) * keep) / 256;
		else if (dir < 1 && v > 0)
			v = (v * keep) / 256;
		if (dir > 0 && v < lim)
			v++;
		else if (dir < 0 && v > -lim)
			v--;
		return v;
	endfunction

	// Move of one axis: first-frame step or sign plus scaled quadratic curve
	function automatic int axis_move_units(input int dir, input int v);
		longint units;
		longint curve;
		longint scaled;
		if (frames == 8'd0) begin
			units = longint'(dir) * longint'(first_stp);
		end else begin
			curve = (longint'(v) * 256) / limit_or_one();
			curve = (curve * curve) / 256;
			if (v < 0)
				curve = -curve;
			units = (v > 0) ? 1 : ((v < 0) ? -1 : 0);
			scaled = longint'(top_spd) * curve;
			// floor division by 256
			if (scaled >= 0)
				units += scaled / 256;
			else
				units -= (-scaled + 255) / 256;
		end
		if (units > MOVE_LIMIT)
			units = MOVE_LIMIT;
		else if (units < -MOVE_LIMIT)
			units = -MOVE_LIMIT;
		return int'(units);
	endfunction

	task automatic predict_motion(input logic op, input logic signed [1:0] dx,
		input logic signed [1:0] dy, output result_t r);
		int mx;
		int my;
		int vx;
		int vy;
		mx = 0;
		my = 0;
		r = '0;
		if (op == OP_PRESS) begin
			if (dy != 2'sd0)
				heading_y = dy;
			if (dx != 2'sd0)
				heading_x = dx;
			if (frames == 8'd0) begin
				r.use_start_delay = 1'b1;
				mx = axis_move_units(int'(heading_x), int'(speed_x));
				my = axis_move_units(int'(heading_y), int'(speed_y));
			end
		end else begin
			vx = friction_then_accel(int'(heading_x), int'(speed_x));
			vy = friction_then_accel(int'(heading_y), int'(speed_y));
			speed_x = 8'(vx);
			speed_y = 8'(vy);
			mx = axis_move_units(int'(heading_x), vx);
			my = axis_move_units(int'(heading_y), vy);
			frames = frames + 8'd1;
			if (heading_x == 2'sd0 && heading_y == 2'sd0 && vx == 0 && vy == 0) begin
				frames = 8'd0;
				r.motion_stopped = 1'b1;
			end
		end
		r.move_x = 8'(mx);
		r.move_y = 8'(my);
		r.report_valid = (mx != 0 || my != 0);
	endtask

	// Watch all three channels at each edge
	always @(posedge clk or negedge arst_n) begin : watch
		result_t got;
		result_t want;
		result_t next_move;
		if (!arst_n) begin
			accel_lim = 7'd32;
			top_spd = 8'd16;
			friction = 8'd24;
			first_stp = 7'd1;
			speed_x = '0;
			speed_y = '0;
			frames = '0;
			heading_x = '0;
			heading_y = '0;
			moves_due.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			// result transfer against the oldest prediction
			if (result.valid && result.ready) begin
				got.move_x = result.move_x;
				got.move_y = result.move_y;
				got.report_valid = result.report_valid;
				got.motion_stopped = result.motion_stopped;
				got.use_start_delay = result.use_start_delay;
				if (moves_due.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result: x=%0d y=%0d rv=%0b stop=%0b sd=%0b",
							got.move_x, got.move_y, got.report_valid,
							got.motion_stopped, got.use_start_delay);
					fail_count++;
				end else begin
					want = moves_due.pop_front();
					if (got.move_x !== want.move_x || got.move_y !== want.move_y ||
						got.report_valid !== want.report_valid ||
						got.motion_stopped !== want.motion_stopped ||
						got.use_start_delay !== want.use_start_delay) begin
						if (fail_count < 10)
							$display({"mismatch: expected x=%0d y=%0d rv=%0b stop=%0b sd=%0b,",
								" got x=%0d y=%0d rv=%0b stop=%0b sd=%0b"},
								want.move_x, want.move_y, want.report_valid,
								want.motion_stopped, want.use_start_delay,
								got.move_x, got.move_y, got.report_valid,
								got.motion_stopped, got.use_start_delay);
						fail_count++;
					end
				end
			end
			// register writes
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_ACCEL_LIMIT: accel_lim = cfg.data[6:0];
					REG_TOP_SPEED:   top_spd = cfg.data;
					REG_FRICTION:    friction = cfg.data;
					REG_FIRST_STEP:  first_stp = cfg.data[6:0];
					default: ;
				endcase
			end
			// item transfer
			if (item.valid && item.ready) begin
				predict_motion(item.op, item.press_x_dir, item.press_y_dir, next_move);
				moves_due.push_back(next_move);
			end
			outstanding <= moves_due.size();
		end
	end

endmodule

// ===== sim/tb_pointer_inertia_motion.sv =====
// Stimulus and verdict for the pointer inertia motion block.
module tb_pointer_inertia_motion;
	import pim_pkg::*;
	import pim_tb_pkg::*;

	logic clk;
	logic arst_n;
	logic steady;
	int   mismatches;
	int   outstanding;

	pim_item_if   item();
	pim_result_if result();
	pim_cfg_if    cfg();

	pointer_inertia_motion u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cfg    (cfg)
	);

	pim_motion_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.result      (result),
		.cfg         (cfg),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit
	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

	// Receiver backpressure
	initial begin
		result.ready <= 1'b0;
		forever begin
			@(posedge clk);
			result.ready <= steady || ($urandom_range(99) >= 27);
		end
	end

	function automatic logic signed [1:0] any_heading();
		return 2'($urandom_range(3));
	endfunction

	// One item transfer, with an occasional gap ahead of it
	task automatic send_item(input item_op_t op, input logic signed [1:0] dx,
		input logic signed [1:0] dy);
		int gap;
		if (!steady && $urandom_range(99) < 27) begin
			gap = $urandom_range(1, ($urandom_range(3) == 0) ? 60 : 4);
			item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.valid <= 1'b1;
		item.op <= op;
		item.press_x_dir <= dx;
		item.press_y_dir <= dy;
		do @(posedge clk); while (!item.ready);
	endtask

	// Wait until every predicted result has come back, then let the block go idle
	task automatic settle();
		item.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Write all four registers back to back
	task automatic load_regs(input logic [7:0] limit, input logic [7:0] speed,
		input logic [7:0] fric, input logic [7:0] step);
		cfg.valid <= 1'b1;
		cfg.index <= REG_ACCEL_LIMIT;
		cfg.data <= limit;
		do @(posedge clk); while (!cfg.ready);
		cfg.index <= REG_TOP_SPEED;
		cfg.data <= speed;
		do @(posedge clk); while (!cfg.ready);
		cfg.index <= REG_FRICTION;
		cfg.data <= fric;
		do @(posedge clk); while (!cfg.ready);
		cfg.index <= REG_FIRST_STEP;
		cfg.data <= step;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly a press followed by a run of ticks, with some stray items
	task automatic run_phase(input int budget, input bit long_run);
		int done;
		int run;
		done = 0;
		if (long_run) begin
			// long enough to reach full speed and wrap the frame count
			send_item(OP_PRESS, 2'sd1, 2'sd1);
			repeat (300) send_item(OP_TICK, any_heading(), any_heading());
			done = 301;
		end
		while (done < budget) begin
			if ($urandom_range(99) < 80) begin
				send_item(OP_PRESS, any_heading(), any_heading());
				run = $urandom_range(1, 40);
				repeat (run) send_item(OP_TICK, any_heading(), any_heading());
				done += run + 1;
			end else begin
				send_item(item_op_t'($urandom_range(1)), any_heading(), any_heading());
				done++;
			end
		end
	endtask

	initial begin
		item.valid <= 1'b0;
		item.op <= OP_TICK;
		item.press_x_dir <= 2'sd0;
		item.press_y_dir <= 2'sd0;
		cfg.valid <= 1'b0;
		cfg.index <= REG_ACCEL_LIMIT;
		cfg.data <= 8'd0;
		steady <= 1'b0;
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle tick stops at once; press on frame zero with no heading yet
		send_item(OP_TICK, 2'sd0, 2'sd0);
		send_item(OP_PRESS, 2'sd0, 2'sd0);
		settle();

		// zero accel limit, full friction, largest first step
		load_regs(8'd0, 8'd255, 8'd255, 8'd127);
		send_item(OP_PRESS, 2'b10, 2'sd1);     // -2 heading saturates on frame zero
		send_item(OP_TICK, 2'sd0, 2'sd0);       // first-frame tick
		send_item(OP_PRESS, 2'sd1, 2'b11);     // press after first frame: no move
		repeat (3) send_item(OP_TICK, 2'sd0, 2'sd0);
		settle();

		// back to defaults, then reverse both axes so friction acts
		load_regs(8'd32, 8'd16, 8'd24, 8'd1);
		repeat (5) send_item(OP_TICK, 2'b11, 2'b10);
		send_item(OP_PRESS, 2'b11, 2'sd1);
		repeat (6) send_item(OP_TICK, 2'sd1, 2'sd1);
		send_item(OP_PRESS, 2'sd0, 2'b10);
		repeat (3) send_item(OP_TICK, 2'sd0, 2'sd0);
		settle();

		// random phases over several register settings
		load_regs(8'd32, 8'd16, 8'd24, 8'd1);
		run_phase(150, 1'b0);
		settle();

		load_regs(8'd127, 8'd255, 8'd0, 8'd127);
		run_phase(360, 1'b1);
		settle();

		// limit far below the current speed: curve overflows and saturates
		load_regs(8'd1, 8'd200, 8'd128, 8'd64);
		steady <= 1'b1;
		run_phase(180, 1'b0);
		settle();
		steady <= 1'b0;

		load_regs(8'($urandom_range(1, 127)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(127)));
		run_phase(180, 1'b0);
		settle();

		load_regs(8'd5, 8'd0, 8'd255, 8'd0);
		run_phase(180, 1'b0);
		settle();

		if (mismatches == 0 && outstanding == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/pim_pkg.sv
hdl/pim_channels.sv
hdl/pim_divider.sv
hdl/pim_datapath.sv
hdl/pim_sequencer.sv
hdl/pointer_inertia_motion.sv
sim/pim_tb_pkg.sv
sim/pim_motion_checker.sv
sim/tb_pointer_inertia_motion.sv
